@@ sv/line_follow_steering_controller_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the line follow steering controller
// Concurrent check wrappers; compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_STEERING_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOW_STEERING_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check gated off while reset is asserted
`define LFS_ASSERT(lbl, clk_, rst_n_, prop, msg) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) prop) else $error(msg);
// check that also runs through reset
`define LFS_ASSERT_ALWAYS(lbl, clk_, prop, msg) \
	lbl: assert property (@(posedge clk_) prop) else $error(msg);
`else
`define LFS_ASSERT(lbl, clk_, rst_n_, prop, msg)
`define LFS_ASSERT_ALWAYS(lbl, clk_, prop, msg)
`endif

`endif

@@ sv/lfs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfs_pkg
// Widths, register indexes and reset values of the steering controller.
// ---------------------------------------------------------------------------
package lfs_pkg;

	localparam int SPEED_W   = 8;
	localparam int TICKS_W   = 16;
	localparam int BATT_W    = 12;
	localparam int COUNT_W   = 4;
	localparam int ELAPSED_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;

	localparam logic [SPEED_W-1:0] TRAVEL_SPEED_RST  = 8'd100;
	localparam logic [SPEED_W-1:0] CORR_STEP_RST     = 8'd20;
	localparam logic [TICKS_W-1:0] RAMP_TICKS_RST    = 16'd50;
	localparam logic [TICKS_W-1:0] TIME_LIMIT_RST    = 16'd5000;
	localparam logic [COUNT_W-1:0] LINES_TO_STOP_RST = 4'd3;
	localparam logic [BATT_W-1:0]  BATT_LOW_CODE_RST = 12'd2184;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRAVEL_SPEED   = 3'd0,
		REG_CORR_STEP      = 3'd1,
		REG_RAMP_TICKS     = 3'd2,
		REG_TIME_LIMIT     = 3'd3,
		REG_LINES_TO_STOP  = 3'd4,
		REG_BATT_LOW_CODE  = 3'd5
	} cfg_idx_t;

endpackage

@@ sv/lfs_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfs channel interfaces
// Valid/ready channels for ticks, results and register writes.
// ---------------------------------------------------------------------------
interface lfs_tick_if import lfs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              sensor_l3;
	logic              sensor_l2;
	logic              sensor_l1;
	logic              sensor_r1;
	logic              sensor_r2;
	logic              sensor_r3;
	logic [BATT_W-1:0] battery_code;

	modport source (output valid, sensor_l3, sensor_l2, sensor_l1, sensor_r1, sensor_r2,
		sensor_r3, battery_code, input ready);
	modport sink (input valid, sensor_l3, sensor_l2, sensor_l1, sensor_r1, sensor_r2,
		sensor_r3, battery_code, output ready);
endinterface

interface lfs_result_if import lfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] left_speed;
	logic [SPEED_W-1:0] right_speed;
	logic               motor_on;
	logic               battery_low;
	logic [COUNT_W-1:0] lines_seen;

	modport source (output valid, left_speed, right_speed, motor_on, battery_low,
		lines_seen, input ready);
	modport sink (input valid, left_speed, right_speed, motor_on, battery_low,
		lines_seen, output ready);
endinterface

interface lfs_cfg_if import lfs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/line_follow_steering_controller.sv @@
`timescale 1ns / 1ps
// A tick word is captured in the input stage; the state update writes its result
// word into the result stage. Throughput: one tick word per cycle while the result
// side does not stall; input and result stage form a two-entry pipeline.
// Reset: arst_n low clears pipeline valids and all run state, and loads the
// register defaults; cfg writes are always accepted.
// ---------------------------------------------------------------------------
// line_follow_steering_controller
// Per-tick track speed steering, line counting, timeout and battery check.
// ---------------------------------------------------------------------------
`include "line_follow_steering_controller_assert.svh"

module line_follow_steering_controller import lfs_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	lfs_tick_if.sink     tick,
	lfs_result_if.source result,
	lfs_cfg_if.sink      cfg
);

	// configuration
	logic [SPEED_W-1:0] travel_speed_q, corr_step_q;
	logic [TICKS_W-1:0] ramp_ticks_q, time_limit_q;
	logic [COUNT_W-1:0] lines_to_stop_q;
	logic [BATT_W-1:0]  batt_low_code_q;

	// run state
	logic [SPEED_W-1:0]   left_q, right_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [TICKS_W-1:0]   phase_q;
	logic                 nonzero_q, armed_q, running_q, low_batt_q;
	logic [COUNT_W-1:0]   count_q;

	// input stage
	logic              valid_s1;
	logic              l3_s1, l2_s1, l1_s1, r1_s1, r2_s1, r3_s1;
	logic [BATT_W-1:0] code_s1;

	// result stage
	logic               valid_s2;
	logic [SPEED_W-1:0] left_s2, right_s2;
	logic               motor_s2, batt_s2;
	logic [COUNT_W-1:0] lines_s2;

	logic tick_acc, adv;

	// next state
	logic                 low_batt_n, start, run_a, run_n, clr, ramp_go;
	logic signed [9:0]    lim;
	logic [SPEED_W-1:0]   la, ra;
	logic                 armed_n;
	logic [COUNT_W-1:0]   count_n;
	logic [ELAPSED_W-1:0] elapsed_n;
	logic [TICKS_W-1:0]   ramp_eff, base, phase_n;
	logic [TICKS_W:0]     p1;

	function automatic logic below_lim(input logic [SPEED_W-1:0] x,
		input logic signed [9:0] l);
		return $signed({2'b00, x}) < l;
	endfunction

	assign adv      = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || adv;
	assign tick_acc = tick.valid && tick.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		low_batt_n = low_batt_q || (code_s1 <= batt_low_code_q);
		start      = !running_q && (elapsed_q <= {1'b0, time_limit_q});
		run_a      = running_q || start;
		lim        = $signed({2'b00, travel_speed_q}) - $signed({2'b00, corr_step_q});
		la         = start ? travel_speed_q : left_q;
		ra         = start ? travel_speed_q : right_q;
		clr        = 1'b0;
		ramp_go    = l1_s1 && r1_s1 && nonzero_q && (phase_q == '0);

		if (ramp_go) begin
			if (la < ra && below_lim(la, lim)) la = la + corr_step_q;
			if (ra < la && below_lim(ra, lim)) ra = ra + corr_step_q;
			if (la == ra && below_lim(la, lim)) begin
				la = la + corr_step_q;
				ra = ra + corr_step_q;
			end
		end
		if (l1_s1 && !r1_s1) begin
			if (la > corr_step_q) la = la - corr_step_q;
			if (below_lim(ra, lim)) ra = ra + corr_step_q;
			clr = 1'b1;
		end
		if (!l1_s1 && r1_s1) begin
			if (below_lim(la, lim)) la = la + corr_step_q;
			if (ra > corr_step_q) ra = ra - corr_step_q;
			clr = 1'b1;
		end
		if (l2_s1 && !r2_s1) begin
			la  = '0;
			ra  = travel_speed_q;
			clr = 1'b1;
		end
		if (r2_s1 && !l2_s1) begin
			la  = travel_speed_q;
			ra  = '0;
			clr = 1'b1;
		end

		armed_n = armed_q;
		count_n = count_q;
		if (l3_s1 && r3_s1) begin
			armed_n = 1'b1;
		end else if (armed_q) begin
			if (count_q != COUNT_MAX) count_n = count_q + 1'b1;
			armed_n = 1'b0;
		end

		run_n = run_a;
		if (run_a && ((elapsed_q > {1'b0, time_limit_q}) || (count_n >= lines_to_stop_q)))
			run_n = 1'b0;

		elapsed_n = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
		ramp_eff  = (ramp_ticks_q == '0) ? TICKS_W'(1) : ramp_ticks_q;
		base      = clr ? '0 : phase_q;
		p1        = {1'b0, base} + 1'b1;
		phase_n   = (p1 >= {1'b0, ramp_eff}) ? '0 : p1[TICKS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_speed_q  <= TRAVEL_SPEED_RST;
			corr_step_q     <= CORR_STEP_RST;
			ramp_ticks_q    <= RAMP_TICKS_RST;
			time_limit_q    <= TIME_LIMIT_RST;
			lines_to_stop_q <= LINES_TO_STOP_RST;
			batt_low_code_q <= BATT_LOW_CODE_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_TRAVEL_SPEED:  travel_speed_q  <= cfg.data[SPEED_W-1:0];
				REG_CORR_STEP:     corr_step_q     <= cfg.data[SPEED_W-1:0];
				REG_RAMP_TICKS:    ramp_ticks_q    <= cfg.data[TICKS_W-1:0];
				REG_TIME_LIMIT:    time_limit_q    <= cfg.data[TICKS_W-1:0];
				REG_LINES_TO_STOP: lines_to_stop_q <= cfg.data[COUNT_W-1:0];
				REG_BATT_LOW_CODE: batt_low_code_q <= cfg.data[BATT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			right_q    <= '0;
			elapsed_q  <= '0;
			phase_q    <= '0;
			nonzero_q  <= 1'b0;
			armed_q    <= 1'b0;
			count_q    <= '0;
			running_q  <= 1'b0;
			low_batt_q <= 1'b0;
		end else if (adv) begin
			left_q     <= la;
			right_q    <= ra;
			elapsed_q  <= elapsed_n;
			phase_q    <= phase_n;
			nonzero_q  <= 1'b1;
			armed_q    <= armed_n;
			count_q    <= count_n;
			running_q  <= run_n;
			low_batt_q <= low_batt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= tick_acc || (valid_s1 && !adv);
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			l3_s1   <= tick.sensor_l3;
			l2_s1   <= tick.sensor_l2;
			l1_s1   <= tick.sensor_l1;
			r1_s1   <= tick.sensor_r1;
			r2_s1   <= tick.sensor_r2;
			r3_s1   <= tick.sensor_r3;
			code_s1 <= tick.battery_code;
		end
		if (adv) begin
			left_s2  <= la;
			right_s2 <= ra;
			motor_s2 <= run_n && !low_batt_n;
			batt_s2  <= low_batt_n;
			lines_s2 <= count_n;
		end
	end

	assign result.valid       = valid_s2;
	assign result.left_speed  = left_s2;
	assign result.right_speed = right_s2;
	assign result.motor_on    = motor_s2;
	assign result.battery_low = batt_s2;
	assign result.lines_seen  = lines_s2;

	`LFS_ASSERT(a_batt_latch_holds, clk, arst_n, $past(low_batt_q) |-> low_batt_q, "battery latch cleared")
	`LFS_ASSERT(a_count_monotonic, clk, arst_n, count_q >= $past(count_q), "line count decreased")
	`LFS_ASSERT(a_elapsed_monotonic, clk, arst_n, elapsed_q >= $past(elapsed_q), "elapsed timer went back")
	`LFS_ASSERT(a_no_accept_when_full, clk, arst_n, (valid_s1 && !adv) |-> !tick_acc, "tick word taken over a stalled stage")
	`LFS_ASSERT(a_motor_needs_battery, clk, arst_n, (valid_s2 && motor_s2) |-> !batt_s2, "motor on with low battery")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for line_follow_steering_controller. Tick words are
// driven through directed steering, register-extreme, timeout, line-count and
// battery checks plus long random track-following runs under varied idling.
// Every accepted tick is run through a local model of the steering rules and
// each result word is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb import lfs_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTS     = 40;

	typedef struct packed {
		logic              l3;
		logic              l2;
		logic              l1;
		logic              r1;
		logic              r2;
		logic              r3;
		logic [BATT_W-1:0] batt;
	} tick_t;

	typedef struct packed {
		logic [SPEED_W-1:0] left_spd;
		logic [SPEED_W-1:0] right_spd;
		logic               motor;
		logic               batt_low;
		logic [COUNT_W-1:0] lines;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n;

	lfs_tick_if   tick_if();
	lfs_result_if res_if();
	lfs_cfg_if    cfg_if();

	line_follow_steering_controller DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// model registers
	logic [SPEED_W-1:0] m_travel     = TRAVEL_SPEED_RST;
	logic [SPEED_W-1:0] m_step       = CORR_STEP_RST;
	logic [TICKS_W-1:0] m_ramp       = RAMP_TICKS_RST;
	logic [TICKS_W-1:0] m_limit      = TIME_LIMIT_RST;
	logic [COUNT_W-1:0] m_lines_stop = LINES_TO_STOP_RST;
	logic [BATT_W-1:0]  m_batt_low   = BATT_LOW_CODE_RST;

	// model run state
	logic [SPEED_W-1:0]   left_trk    = '0;
	logic [SPEED_W-1:0]   right_trk   = '0;
	logic [ELAPSED_W-1:0] elapsed     = '0;
	logic [TICKS_W-1:0]   phase       = '0;
	logic                 phase_moved = 1'b0;
	logic                 armed       = 1'b0;
	logic [COUNT_W-1:0]   crossings   = '0;
	logic                 running     = 1'b0;
	logic                 batt_latch  = 1'b0;

	steer_t steer_q[$];
	int     errors         = 0;
	int     send_idle_pct  = 0;
	int     recv_stall_pct = 0;
	int     idle_cycles    = 0;

	function automatic steer_t next_steer(tick_t t);
		int     tv, cs, lim, ls, rs, rp;
		steer_t r;
		tv  = int'(m_travel);
		cs  = int'(m_step);
		lim = tv - cs;
		if (t.batt <= m_batt_low)
			batt_latch = 1'b1;
		if (!running && elapsed <= m_limit) begin
			running   = 1'b1;
			left_trk  = m_travel;
			right_trk = m_travel;
		end
		ls = int'(left_trk);
		rs = int'(right_trk);
		// ramp back toward travel speed on each completed straight interval
		if (t.l1 && t.r1 && phase_moved && phase == '0) begin
			if (ls < rs && ls < lim)
				ls += cs;
			if (rs < ls && rs < lim)
				rs += cs;
			if (ls == rs && ls < lim) begin
				ls += cs;
				rs += cs;
			end
		end
		if (t.l1 && !t.r1) begin
			if (ls > cs)
				ls -= cs;
			if (rs < lim)
				rs += cs;
			phase       = '0;
			phase_moved = 1'b0;
		end
		if (!t.l1 && t.r1) begin
			if (ls < lim)
				ls += cs;
			if (rs > cs)
				rs -= cs;
			phase       = '0;
			phase_moved = 1'b0;
		end
		if (t.l2 && !t.r2) begin
			ls          = 0;
			rs          = tv;
			phase       = '0;
			phase_moved = 1'b0;
		end
		if (t.r2 && !t.l2) begin
			ls          = tv;
			rs          = 0;
			phase       = '0;
			phase_moved = 1'b0;
		end
		left_trk  = ls[SPEED_W-1:0];
		right_trk = rs[SPEED_W-1:0];
		if (t.l3 && t.r3) begin
			armed = 1'b1;
		end else if (armed) begin
			if (crossings != COUNT_MAX)
				crossings++;
			armed = 1'b0;
		end
		if (running && (elapsed > m_limit || crossings >= m_lines_stop))
			running = 1'b0;
		r.left_spd  = left_trk;
		r.right_spd = right_trk;
		r.motor     = running && !batt_latch;
		r.batt_low  = batt_latch;
		r.lines     = crossings;
		if (elapsed != ELAPSED_MAX)
			elapsed++;
		rp = (m_ramp == '0) ? 1 : int'(m_ramp);
		if (int'(phase) + 1 >= rp)
			phase = '0;
		else
			phase++;
		phase_moved = 1'b1;
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		steer_t got, want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				got = {res_if.left_speed, res_if.right_speed, res_if.motor_on,
					res_if.battery_low, res_if.lines_seen};
				if (steer_q.size() == 0) begin
					report("result word with nothing expected", int'(got.left_spd), 0);
				end else begin
					want = steer_q.pop_front();
					if (got.left_spd != want.left_spd)
						report("left_speed", int'(got.left_spd), int'(want.left_spd));
					if (got.right_spd != want.right_spd)
						report("right_speed", int'(got.right_spd), int'(want.right_spd));
					if (got.motor != want.motor)
						report("motor_on", int'(got.motor), int'(want.motor));
					if (got.batt_low != want.batt_low)
						report("battery_low", int'(got.batt_low), int'(want.batt_low));
					if (got.lines != want.lines)
						report("lines_seen", int'(got.lines), int'(want.lines));
				end
			end
			if (tick_if.valid && tick_if.ready)
				steer_q.push_back(next_steer({tick_if.sensor_l3, tick_if.sensor_l2,
					tick_if.sensor_l1, tick_if.sensor_r1, tick_if.sensor_r2,
					tick_if.sensor_r3, tick_if.battery_code}));
		end
		res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic tick_t sensors(int l3, int l2, int l1, int r1, int r2, int r3,
			int batt);
		tick_t t;
		t.l3   = l3[0];
		t.l2   = l2[0];
		t.l1   = l1[0];
		t.r1   = r1[0];
		t.r2   = r2[0];
		t.r3   = r3[0];
		t.batt = batt[BATT_W-1:0];
		return t;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int    roll;
		t    = '0;
		roll = $urandom_range(99);
		if (roll < 40) begin
			t.l1 = 1'b1;
			t.r1 = 1'b1;
			if ($urandom_range(3) == 0) begin
				t.l2 = 1'b1;
				t.r2 = 1'b1;
			end
		end else if (roll < 70) begin
			if ($urandom_range(1))
				t.l1 = 1'b1;
			else
				t.r1 = 1'b1;
		end else if (roll < 82) begin
			if ($urandom_range(1))
				t.l2 = 1'b1;
			else
				t.r2 = 1'b1;
			t.l1 = 1'($urandom_range(1));
			t.r1 = 1'($urandom_range(1));
		end else begin
			t.l2 = 1'($urandom_range(1));
			t.l1 = 1'($urandom_range(1));
			t.r1 = 1'($urandom_range(1));
			t.r2 = 1'($urandom_range(1));
		end
		// crossings kept rare so the line target is not reached early
		if ($urandom_range(399) == 0) begin
			t.l3 = 1'b1;
			t.r3 = 1'b1;
		end else if ($urandom_range(7) == 0) begin
			if ($urandom_range(1))
				t.l3 = 1'b1;
			else
				t.r3 = 1'b1;
		end
		t.batt = BATT_W'($urandom_range(4095, int'(m_batt_low) + 1));
		return t;
	endfunction

	// call only right after a rising edge
	task automatic send_tick(tick_t t);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			tick_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		tick_if.valid        <= 1'b1;
		tick_if.sensor_l3    <= t.l3;
		tick_if.sensor_l2    <= t.l2;
		tick_if.sensor_l1    <= t.l1;
		tick_if.sensor_r1    <= t.r1;
		tick_if.sensor_r2    <= t.r2;
		tick_if.sensor_r3    <= t.r3;
		tick_if.battery_code <= t.batt;
		do
			@(posedge clk);
		while (!tick_if.ready);
	endtask

	task automatic drain();
		tick_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (steer_q.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			REG_TRAVEL_SPEED:  m_travel     = val[SPEED_W-1:0];
			REG_CORR_STEP:     m_step       = val[SPEED_W-1:0];
			REG_RAMP_TICKS:    m_ramp       = val[TICKS_W-1:0];
			REG_TIME_LIMIT:    m_limit      = val[TICKS_W-1:0];
			REG_LINES_TO_STOP: m_lines_stop = val[COUNT_W-1:0];
			REG_BATT_LOW_CODE: m_batt_low   = val[BATT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(int travel, int step, int ramp, int limit, int lines, int batt);
		drain();
		write_reg(REG_TRAVEL_SPEED, CFG_DAT_W'(travel));
		write_reg(REG_CORR_STEP, CFG_DAT_W'(step));
		write_reg(REG_RAMP_TICKS, CFG_DAT_W'(ramp));
		write_reg(REG_TIME_LIMIT, CFG_DAT_W'(limit));
		write_reg(REG_LINES_TO_STOP, CFG_DAT_W'(lines));
		write_reg(REG_BATT_LOW_CODE, CFG_DAT_W'(batt));
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_centered(int n);
		repeat (n)
			send_tick(sensors(0, 0, 1, 1, 0, 0, 4095));
	endtask

	task automatic test_steering();
		send_centered(2);
		send_tick(sensors(0, 0, 1, 0, 0, 0, 4095));
		send_tick(sensors(0, 0, 0, 1, 0, 0, 4095));
		send_tick(sensors(0, 1, 0, 0, 0, 0, 4095));
		send_tick(sensors(0, 0, 0, 0, 1, 0, 4095));
		send_tick(sensors(0, 1, 0, 0, 1, 0, 4095));
		send_tick(sensors(0, 0, 0, 0, 0, 0, 4095));
		send_tick(sensors(1, 1, 1, 1, 1, 1, 4095));
		send_tick(sensors(0, 0, 0, 0, 0, 0, 4095));
		send_tick(sensors(0, 0, 1, 1, 0, 0, int'(BATT_LOW_CODE_RST) + 1));
	endtask

	task automatic test_config_extremes();
		// zero ramp acts as one, zero step
		configure(255, 0, 0, 65535, 15, 0);
		send_tick(sensors(0, 0, 1, 0, 0, 0, 4095));
		send_centered(2);
		// step above travel speed: signed limit blocks every increase
		configure(10, 200, 1, 65535, 15, 0);
		send_tick(sensors(0, 0, 1, 0, 0, 0, 4095));
		send_tick(sensors(0, 0, 0, 1, 0, 0, 4095));
		send_centered(2);
		configure(0, 255, 65535, 65535, 15, 0);
		send_tick(sensors(0, 1, 0, 0, 0, 0, 4095));
		send_centered(1);
		configure(100, 5, 40, 65535, 15, 0);
		send_tick(sensors(0, 0, 0, 1, 0, 0, 4095));
		send_centered(20);
		// ramp interval lowered below the running phase
		configure(100, 5, 8, 65535, 15, 0);
		send_centered(10);
	endtask

	task automatic test_timeout();
		drain();
		configure(100, 20, 50, int'(elapsed) + 2, 15, 0);
		send_centered(5);
		configure(100, 20, 50, 0, 15, 0);
		send_centered(2);
		configure(100, 20, 50, 65535, 15, 0);
		send_centered(2);
	endtask

	task automatic random_phase(int idle_pct, int stall_pct, int n, bit hold_mid);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2)
				drain();
			send_tick(random_tick());
		end
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_random();
		configure(255, $urandom_range(40), $urandom_range(4, 1), 65535, 15, 0);
		random_phase(0, 0, 450, 1'b0);
		configure($urandom_range(255), $urandom_range(60), $urandom_range(8, 1), 65535, 15,
			$urandom_range(2000));
		random_phase(75, 0, 450, 1'b1);
		configure($urandom_range(200, 40), $urandom_range(255), 0, 65535, 15, 0);
		random_phase(0, 75, 450, 1'b0);
		configure($urandom_range(255), $urandom_range(30), $urandom_range(3, 1), 65535, 15,
			$urandom_range(1000));
		random_phase(18, 18, 450, 1'b0);
	endtask

	task automatic test_line_target();
		// zero target: the count always meets it
		configure(100, 20, 4, 65535, 0, 0);
		send_centered(2);
		drain();
		configure(100, 20, 4, 65535, int'(crossings) + 1, 0);
		send_centered(1);
		send_tick(sensors(1, 0, 1, 1, 0, 1, 4095));
		send_tick(sensors(1, 0, 1, 1, 0, 1, 4095));
		send_centered(3);
	endtask

	task automatic test_battery_low();
		configure(100, 20, 50, 65535, 15, 3000);
		send_tick(sensors(0, 0, 1, 1, 0, 0, 3001));
		send_tick(sensors(0, 0, 1, 1, 0, 0, 3000));
		send_tick(sensors(0, 0, 1, 0, 0, 0, 4095));
		configure(100, 20, 50, 65535, 15, 4095);
		send_tick(sensors(0, 0, 1, 1, 0, 0, 4095));
		configure(100, 20, 50, 65535, 15, 0);
		send_tick(sensors(0, 0, 1, 1, 0, 0, 0));
	endtask

	task automatic test_count_saturation();
		configure(100, 20, 50, 65535, 15, 0);
		repeat (16) begin
			send_tick(sensors(1, 0, 1, 1, 0, 1, 4095));
			send_centered(1);
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		tick_if.valid        <= 1'b0;
		tick_if.sensor_l3    <= 1'b0;
		tick_if.sensor_l2    <= 1'b0;
		tick_if.sensor_l1    <= 1'b0;
		tick_if.sensor_r1    <= 1'b0;
		tick_if.sensor_r2    <= 1'b0;
		tick_if.sensor_r3    <= 1'b0;
		tick_if.battery_code <= '0;
		cfg_if.valid         <= 1'b0;
		cfg_if.index         <= REG_TRAVEL_SPEED;
		cfg_if.data          <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_steering();
		test_config_extremes();
		test_timeout();
		test_random();
		test_line_target();
		test_battery_low();
		test_count_saturation();

		drain();
		repeat (10)
			@(posedge clk);
		if (errors == 0 && steer_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
